// ===== rtl/bdlp_pkg.sv =====
// Package for the button debounce / long-press block.
// Holds transaction payload types, the mode and kind encodings and status codes.
// No dependencies.
package bdlp_pkg;

    typedef struct packed {
        logic        op;
        logic        pin_level;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] press_duration;
    } t_out_item;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_INIT   = 1'b1;

    localparam logic [2:0] ST_UNSTABLE  = 3'd0;
    localparam logic [2:0] ST_LOW       = 3'd1;
    localparam logic [2:0] ST_HIGH      = 3'd2;
    localparam logic [2:0] ST_PRESS     = 3'd3;
    localparam logic [2:0] ST_LONG      = 3'd4;
    localparam logic [2:0] ST_SHORT_REL = 3'd5;
    localparam logic [2:0] ST_LONG_REL  = 3'd6;
    localparam logic [2:0] ST_INVALID   = 3'd7;

    localparam logic [1:0] CFG_MIN_LOW  = 2'd0;
    localparam logic [1:0] CFG_MIN_HIGH = 2'd1;
    localparam logic [1:0] CFG_LONG     = 2'd2;

    localparam logic [15:0] MIN_LOW_RST  = 16'd50;
    localparam logic [15:0] MIN_HIGH_RST = 16'd50;
    localparam logic [15:0] LONG_RST     = 16'd1000;

    typedef enum logic [4:0] {
        MODE_UNSTABLE = 5'b00001,
        MODE_LOW      = 5'b00010,
        MODE_HIGH     = 5'b00100,
        MODE_QLOW     = 5'b01000,
        MODE_QHIGH    = 5'b10000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PRESS = 2'd1,
        KIND_LONG  = 2'd2
    } t_kind;

    typedef struct packed {
        logic        last_level;
        t_mode       mode;
        logic [31:0] timer_start;
        logic [31:0] press_time;
        t_kind       press_kind;
    } t_state;

    typedef struct packed {
        logic [15:0] min_low_ms;
        logic [15:0] min_high_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

endpackage

// ===== rtl/bdlp_step.sv =====
// Next-state and status logic for one debounce transaction.
// Purely combinational; depends on bdlp_pkg.
module bdlp_step (
    input  bdlp_pkg::t_state    i_state,
    input  bdlp_pkg::t_cfg      i_cfg,
    input  bdlp_pkg::t_in_item  i_item,
    output bdlp_pkg::t_state    o_state,
    output bdlp_pkg::t_out_item o_result
);
    import bdlp_pkg::*;

    logic [31:0] w_since_timer;
    logic [31:0] w_since_press;
    logic [31:0] w_now;
    logic        w_level;
    logic [2:0]  w_status;
    t_state      w_next;

    assign w_now         = i_item.now_ms;
    assign w_level       = i_item.pin_level;
    assign w_since_timer = w_now - i_state.timer_start;
    assign w_since_press = w_now - i_state.press_time;

    always_comb begin
        w_next   = i_state;
        w_status = ST_UNSTABLE;
        if (i_item.op == OP_INIT) begin
            w_next.last_level = w_level;
            w_next.mode       = w_level ? MODE_HIGH : MODE_LOW;
            w_status          = w_level ? ST_HIGH : ST_LOW;
        end else if (i_state.last_level != w_level) begin
            w_next.last_level = w_level;
            w_next.mode       = MODE_UNSTABLE;
        end else begin
            unique case (i_state.mode)
                MODE_QHIGH: begin
                    if (w_since_timer >= {16'd0, i_cfg.min_high_ms}) begin
                        w_next.mode       = MODE_HIGH;
                        w_next.press_kind = KIND_NONE;
                        if (i_state.press_kind == KIND_LONG) begin
                            w_next.press_time = w_since_press;
                            w_status          = ST_LONG_REL;
                        end else if (i_state.press_kind == KIND_PRESS) begin
                            w_next.press_time = w_since_press;
                            w_status          = ST_SHORT_REL;
                        end else begin
                            w_status = ST_INVALID;
                        end
                    end
                end
                MODE_QLOW: begin
                    if (w_since_timer >= {16'd0, i_cfg.min_low_ms}) begin
                        w_next.mode       = MODE_LOW;
                        w_next.press_time = w_now;
                        w_next.press_kind = KIND_PRESS;
                        w_status          = ST_PRESS;
                    end
                end
                MODE_LOW: begin
                    // long press reported once per press
                    if (w_since_press > {16'd0, i_cfg.long_press_ms} &&
                        i_state.press_kind != KIND_LONG) begin
                        w_next.press_kind = KIND_LONG;
                        w_status          = ST_LONG;
                    end else begin
                        w_status = ST_LOW;
                    end
                end
                MODE_HIGH: begin
                    if (w_level) begin
                        w_status = ST_HIGH;
                    end else begin
                        w_next.mode        = MODE_QLOW;
                        w_next.timer_start = w_now;
                    end
                end
                default: begin
                    w_next.mode        = w_level ? MODE_QHIGH : MODE_QLOW;
                    w_next.timer_start = w_now;
                end
            endcase
        end
    end

    assign o_state                 = w_next;
    assign o_result.status         = w_status;
    assign o_result.press_duration = w_next.press_time;

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// Button debounce with long-press detection, top level.
// Path: input register, then result register; state updates as an item moves to the result.
// Throughput: one transaction per cycle unless a held result waits on i_out_ready.
// Reset (synchronous, active low) clears mode to unstable, timers, press kind, and
// restores configuration defaults of 50, 50 and 1000 ms. Depends on bdlp_pkg, bdlp_step.
module button_debounce_long_press (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bdlp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bdlp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import bdlp_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_item n_out;
    logic      w_advance;

    assign w_advance  = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_advance;

    bdlp_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_level  <= 1'b0;
            r_state.mode        <= MODE_UNSTABLE;
            r_state.timer_start <= 32'd0;
            r_state.press_time  <= 32'd0;
            r_state.press_kind  <= KIND_NONE;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_low_ms    <= MIN_LOW_RST;
            r_cfg.min_high_ms   <= MIN_HIGH_RST;
            r_cfg.long_press_ms <= LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LOW:  r_cfg.min_low_ms    <= i_cfg_data;
                CFG_MIN_HIGH: r_cfg.min_high_ms   <= i_cfg_data;
                CFG_LONG:     r_cfg.long_press_ms <= i_cfg_data;
                default:      r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a held result always mirrors the stored press value
    a_dur_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.press_duration == r_state.press_time)
        else $error("result press_duration differs from stored press time");

    a_press_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_PRESS
            |-> r_state.mode == MODE_LOW && r_state.press_kind == KIND_PRESS)
        else $error("press start without low mode and open press");

    a_release_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_SHORT_REL ||
                        o_out_data.status == ST_LONG_REL ||
                        o_out_data.status == ST_INVALID)
            |-> r_state.mode == MODE_HIGH && r_state.press_kind == KIND_NONE)
        else $error("release reported but press not closed");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("state changed without a transaction moving to the result");
`endif

endmodule
